FILE: hdl/dqd_pkg.sv
// Package for the bounded deque core: request and status codes, result
// word layout and fixed port widths.
// No dependencies.
package dqd_pkg;

    // Fixed widths of the request and result fields
    localparam int REQ_W      = 4;
    localparam int ARG_W      = 32;
    localparam int ITEM_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int LIST_LEN_W = 7;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 4'd4;
    localparam logic [REQ_W-1:0] REQ_READ_ALL   = 4'd5;
    localparam logic [REQ_W-1:0] REQ_READ_FIRST = 4'd6;
    localparam logic [REQ_W-1:0] REQ_READ_LAST  = 4'd7;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd8;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // One result word as handed to the output stage
    typedef struct packed {
        logic [ITEM_W-1:0]     item_value;
        logic                  is_last;
        logic [STATUS_W-1:0]   status;
        logic [LIST_LEN_W-1:0] list_length;
    } dqd_result_t;

endpackage

FILE: hdl/bounded_deque_with_value_delete_core.sv
// Bounded deque of signed words with delete-by-value, held in a ring store
// (one write port, one registered read port) and driven by a small sequencer
// with one shared modulo address unit. Push, pop, clear and unknown codes
// go through the decode and response states to the output register. Delete
// walks the list entry by entry (read, then compare and compact-write). A
// read issues and emits its entries one at a time, each waiting on m_ready.
// s_ready is high only between requests.
// Depends on dqd_pkg, dqd_slot_calc and dqd_out_reg.
module bounded_deque_with_value_delete_core
    import dqd_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [REQ_W-1:0]        s_req_type,
    input  logic signed [ARG_W-1:0] s_argument,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [ITEM_W-1:0] m_item_value,
    output logic                    m_is_last,
    output logic [STATUS_W-1:0]     m_status,
    output logic [LIST_LEN_W-1:0]   m_list_length
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DEL_RD,
        S_DEL_CMP,
        S_RD_ISSUE,
        S_RD_EMIT,
        S_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [REQ_W-1:0]        req_reg, req_next;
    logic signed [ARG_W-1:0] arg_reg, arg_next;
    logic [IDX_W-1:0]        front_reg, front_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        keep_reg, keep_next;
    logic [CNT_W-1:0]        num_reg, num_next;
    logic [CNT_W-1:0]        start_reg, start_next;
    logic [STATUS_W-1:0]     status_reg, status_next;

    // Ring store
    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] rdata_reg;
    logic                   mem_we;
    logic                   mem_re;

    // Shared address unit
    logic [IDX_W-1:0] addr_off;
    logic [IDX_W-1:0] slot;

    // Output stage handshake
    logic        out_load;
    logic        out_free;
    dqd_result_t out_data;

    // Derived values
    logic [63:0]            arg_ext;
    logic [63:0]            rd_ext;
    logic [VALUE_WIDTH-1:0] val_cur;
    logic [CNT_W-1:0]       rd_pos;
    logic [CNT_W-1:0]       idx_inc;
    logic [CNT_W-1:0]       n_calc;
    logic [CNT_W-1:0]       start_calc;
    logic                   is_full;
    logic                   is_empty;

    assign arg_ext  = 64'(arg_reg);
    assign val_cur  = arg_ext[VALUE_WIDTH-1:0];
    assign rd_ext   = 64'(rdata_reg);
    assign rd_pos   = start_reg + idx_reg;
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign s_ready  = (state_reg == S_IDLE);

    // Entry count for the read requests, clamped to the length (zero if negative)
    always_comb begin
        if (req_reg == REQ_READ_ALL) begin
            n_calc = count_reg;
        end else if (arg_reg[ARG_W-1]) begin
            n_calc = '0;
        end else if ($unsigned(arg_reg) > ARG_W'(count_reg)) begin
            n_calc = count_reg;
        end else begin
            n_calc = arg_reg[CNT_W-1:0];
        end
        start_calc = (req_reg == REQ_READ_LAST) ? (count_reg - n_calc) : '0;
    end

    // Offset fed to the shared address unit in each step
    always_comb begin
        addr_off = '0;
        case (state_reg)
            S_DECODE: begin
                case (req_reg)
                    REQ_PUSH_FRONT: addr_off = IDX_W'(CAPACITY - 1);
                    REQ_PUSH_BACK:  addr_off = count_reg[IDX_W-1:0];
                    REQ_POP_FRONT:  addr_off = IDX_W'(1);
                    default:        addr_off = '0;
                endcase
            end
            S_DEL_RD:   addr_off = idx_reg[IDX_W-1:0];
            S_DEL_CMP:  addr_off = keep_reg[IDX_W-1:0];
            S_RD_ISSUE: addr_off = rd_pos[IDX_W-1:0];
            default:    addr_off = '0;
        endcase
    end

    dqd_slot_calc #(
        .CAPACITY(CAPACITY)
    ) u_slot (
        .base_idx(front_reg),
        .offset  (addr_off),
        .slot    (slot)
    );

    // Sequencer next-state and datapath control
    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        arg_next    = arg_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        keep_next   = keep_reg;
        num_next    = num_reg;
        start_next  = start_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        out_load    = 1'b0;
        out_data.item_value  = '0;
        out_data.is_last     = 1'b1;
        out_data.status      = status_reg;
        out_data.list_length = LIST_LEN_W'(count_reg);

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next    = s_req_type;
                    arg_next    = s_argument;
                    status_next = ST_OK;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE: begin
                state_next = S_RESP;
                case (req_reg)
                    REQ_PUSH_FRONT: begin
                        if (is_full) begin
                            status_next = ST_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            front_next = slot;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    REQ_PUSH_BACK: begin
                        if (is_full) begin
                            status_next = ST_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    REQ_POP_FRONT: begin
                        if (!is_empty) begin
                            front_next = slot;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    REQ_POP_BACK: begin
                        if (!is_empty) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    REQ_DELETE: begin
                        idx_next   = '0;
                        keep_next  = '0;
                        state_next = S_DEL_RD;
                    end
                    REQ_READ_ALL, REQ_READ_FIRST, REQ_READ_LAST: begin
                        num_next   = n_calc;
                        start_next = start_calc;
                        idx_next   = '0;
                        if (n_calc == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            state_next = S_RD_ISSUE;
                        end
                    end
                    REQ_CLEAR: begin
                        front_next = '0;
                        count_next = '0;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end

            // Delete: read entry i, then keep it at position k if it differs
            S_DEL_RD: begin
                if (idx_reg == count_reg) begin
                    count_next = keep_reg;
                    state_next = S_RESP;
                end else begin
                    mem_re     = 1'b1;
                    idx_next   = idx_inc;
                    state_next = S_DEL_CMP;
                end
            end

            S_DEL_CMP: begin
                if (rdata_reg != val_cur) begin
                    mem_we    = 1'b1;
                    keep_next = keep_reg + CNT_W'(1);
                end
                state_next = S_DEL_RD;
            end

            // Streaming read, front to back
            S_RD_ISSUE: begin
                mem_re     = 1'b1;
                state_next = S_RD_EMIT;
            end

            S_RD_EMIT: begin
                out_data.item_value = rd_ext[ITEM_W-1:0];
                out_data.is_last    = (idx_inc == num_reg);
                out_data.status     = ST_OK;
                if (out_free) begin
                    out_load = 1'b1;
                    idx_next = idx_inc;
                    state_next = (idx_inc == num_reg) ? S_IDLE : S_RD_ISSUE;
                end
            end

            S_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            keep_reg   <= '0;
            num_reg    <= '0;
            start_reg  <= '0;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            keep_reg   <= keep_next;
            num_reg    <= num_next;
            start_reg  <= start_next;
            status_reg <= status_next;
        end
        req_reg <= req_next;
        arg_reg <= arg_next;
    end

    // Ring store: one write, one registered read, both at the shared slot
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[slot] <= (state_reg == S_DEL_CMP) ? rdata_reg : val_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rdata_reg <= mem[slot];
        end
    end

    dqd_out_reg u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_valid   (out_load),
        .load_data    (out_data),
        .load_ready   (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item_value (m_item_value),
        .m_is_last    (m_is_last),
        .m_status     (m_status),
        .m_list_length(m_list_length)
    );

`ifndef SYNTH
    // Length never exceeds the store
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Ring front stays inside the store
    a_front_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        front_reg < IDX_W'(CAPACITY - 1) || front_reg == IDX_W'(CAPACITY - 1))
        else $error("front index outside the ring");

    // A request transfer closes the input until it is done
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input reopened in the cycle after a transfer");

    // The store is only written while a request is in work
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !mem_we)
        else $error("store written while idle");
`endif

endmodule

FILE: hdl/dqd_slot_calc.sv
// Shared ring address unit: (base + offset) modulo CAPACITY.
// Depends on nothing; used by the sequencer for every store access.
module dqd_slot_calc #(
    parameter int CAPACITY = 64
) (
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] base_idx,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] offset,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] slot
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [IDX_W:0] sum;

    // Both operands are below CAPACITY, so one conditional subtract wraps
    always_comb begin
        sum = {1'b0, base_idx} + {1'b0, offset};
        if (sum >= (IDX_W + 1)'(CAPACITY)) begin
            sum = sum - (IDX_W + 1)'(CAPACITY);
        end
        slot = sum[IDX_W-1:0];
    end

endmodule

FILE: hdl/dqd_out_reg.sv
// Single-entry output register for the result channel.
// Depends on dqd_pkg for the result word layout.
module dqd_out_reg
    import dqd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load_valid,
    input  dqd_result_t           load_data,
    output logic                  load_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ITEM_W-1:0]     m_item_value,
    output logic                  m_is_last,
    output logic [STATUS_W-1:0]   m_status,
    output logic [LIST_LEN_W-1:0] m_list_length
);

    logic        valid_reg;
    dqd_result_t data_reg;

    // Slot is free when empty or when its word leaves this cycle
    assign load_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ready && load_valid) begin
            data_reg <= load_data;
        end
    end

    assign m_valid       = valid_reg;
    assign m_item_value  = data_reg.item_value;
    assign m_is_last     = data_reg.is_last;
    assign m_status      = data_reg.status;
    assign m_list_length = data_reg.list_length;

endmodule

FILE: tb/sv/deque_result_checker.sv
// Result checker for the bounded deque core: watches both channels, keeps a
// model of the list and compares every result transfer with the oldest prediction.
// Depends on dqd_pkg.
module deque_result_checker
    import dqd_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic signed [ARG_W-1:0]  s_argument,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [ITEM_W-1:0] m_item_value,
    input  logic                     m_is_last,
    input  logic [STATUS_W-1:0]      m_status,
    input  logic [LIST_LEN_W-1:0]    m_list_length,
    output int                       outstanding,
    output int                       fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // Stored words keep VALUE_WIDTH bits; reads give the low ITEM_W bits
    localparam logic [ITEM_W-1:0] KEEP =
        (VALUE_WIDTH >= ITEM_W) ? '1 : ITEM_W'((64'd1 << VALUE_WIDTH) - 64'd1);

    // Model of the list: ring store, front position and entry count
    logic [ITEM_W-1:0] entry_ring [CAPACITY];
    int                front_pos;
    int                held;

    dqd_result_t pending_results [$];
    dqd_result_t got;
    dqd_result_t want;
    int          result_index;

    function automatic void queue_result(input logic [ITEM_W-1:0] value, input logic last,
                                         input logic [STATUS_W-1:0] st);
        pending_results.push_back('{item_value: value, is_last: last, status: st,
                                    list_length: LIST_LEN_W'(held)});
    endfunction

    // Update the list model for one request and queue the results it causes
    task automatic apply_request(input logic [REQ_W-1:0] req,
                                 input logic signed [ARG_W-1:0] arg);
        logic [ITEM_W-1:0]   word;
        logic [STATUS_W-1:0] st;
        int                  kept;
        int                  n;
        int                  first;
        int                  i;
        word = arg & KEEP;
        st   = ST_OK;
        case (req)
            REQ_PUSH_FRONT: begin
                if (held >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    front_pos = (front_pos + CAPACITY - 1) % CAPACITY;
                    entry_ring[front_pos] = word;
                    held++;
                end
            end
            REQ_PUSH_BACK: begin
                if (held >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    entry_ring[(front_pos + held) % CAPACITY] = word;
                    held++;
                end
            end
            REQ_POP_FRONT: begin
                if (held > 0) begin
                    front_pos = (front_pos + 1) % CAPACITY;
                    held--;
                end
            end
            REQ_POP_BACK: begin
                if (held > 0) held--;
            end
            REQ_DELETE: begin
                // compact survivors toward the front, order kept
                kept = 0;
                for (i = 0; i < held; i++) begin
                    if (entry_ring[(front_pos + i) % CAPACITY] != word) begin
                        entry_ring[(front_pos + kept) % CAPACITY] =
                            entry_ring[(front_pos + i) % CAPACITY];
                        kept++;
                    end
                end
                held = kept;
            end
            REQ_READ_ALL, REQ_READ_FIRST, REQ_READ_LAST: begin
                if (req == REQ_READ_ALL) n = held;
                else if (arg < 0) n = 0;
                else n = (arg > held) ? held : int'(arg);
                first = (req == REQ_READ_LAST) ? held - n : 0;
                if (n == 0) queue_result('0, 1'b1, ST_EMPTY);
                for (i = 0; i < n; i++) begin
                    queue_result(entry_ring[(front_pos + first + i) % CAPACITY],
                                 i == n - 1, ST_OK);
                end
                return;
            end
            REQ_CLEAR: begin
                front_pos = 0;
                held      = 0;
            end
            default: ;
        endcase
        queue_result('0, 1'b1, st);
    endtask

    // Result transfers are checked before the request transfer of the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            front_pos    = 0;
            held         = 0;
            fail_count   = 0;
            result_index = 0;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{item_value: m_item_value, is_last: m_is_last, status: m_status,
                        list_length: m_list_length};
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result %0d unexpected: value %0d last %0b status %0d length %0d",
                                 result_index, $signed(got.item_value), got.is_last,
                                 got.status, got.list_length);
                end else begin
                    want = pending_results.pop_front();
                    if (got.item_value !== want.item_value || got.is_last !== want.is_last ||
                        got.status !== want.status || got.list_length !== want.list_length) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"result %0d: expected value %0d last %0b status %0d ",
                                      "length %0d, got value %0d last %0b status %0d length %0d"},
                                     result_index, $signed(want.item_value), want.is_last,
                                     want.status, want.list_length, $signed(got.item_value),
                                     got.is_last, got.status, got.list_length);
                    end
                end
                result_index++;
            end
            if (s_valid && s_ready) apply_request(s_req_type, s_argument);
        end
        outstanding <= pending_results.size();
    end

endmodule

FILE: tb/sv/bounded_deque_with_value_delete_core_tb.sv
// Testbench top for the bounded deque core: clock, reset, request stimulus,
// result-side stalls, watchdog and verdict.
// Depends on dqd_pkg, deque_result_checker and the core RTL.
module bounded_deque_with_value_delete_core_tb
    import dqd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY       = 64;
    localparam int VALUE_WIDTH    = 32;
    // slowest gap between transfers: a full-list delete plus stalls
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_WAIT       = 5;

    // Request codes the core treats as no-ops
    localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = 4'd9;
    localparam logic [REQ_W-1:0] REQ_LAST_UNUSED  = 4'd15;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [REQ_W-1:0]         s_req_type;
    logic signed [ARG_W-1:0]  s_argument;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [ITEM_W-1:0] m_item_value;
    logic                     m_is_last;
    logic [STATUS_W-1:0]      m_status;
    logic [LIST_LEN_W-1:0]    m_list_length;

    int outstanding;
    int fail_count;
    int idle_cycles = 0;
    bit quiet = 1'b0;

    bounded_deque_with_value_delete_core #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_argument    (s_argument),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item_value  (m_item_value),
        .m_is_last     (m_is_last),
        .m_status      (m_status),
        .m_list_length (m_list_length)
    );

    deque_result_checker #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_argument    (s_argument),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item_value  (m_item_value),
        .m_is_last     (m_is_last),
        .m_status      (m_status),
        .m_list_length (m_list_length),
        .outstanding   (outstanding),
        .fail_count    (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // One request transfer; valid stays up across back-to-back requests
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic signed [ARG_W-1:0] arg);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_argument <= arg;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mostly a small pool so deletes hit, plus extremes and raw random words
    function automatic logic signed [ARG_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1, 2: pick_value = int'($urandom_range(0, 4)) - 2;
            3:       pick_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: pick_value = $urandom;
        endcase
    endfunction

    // Read counts: mostly short, some past the length, some negative
    function automatic logic signed [ARG_W-1:0] pick_count();
        case ($urandom_range(0, 3))
            0, 1:    pick_count = $urandom_range(0, 8);
            2:       pick_count = $urandom_range(0, CAPACITY + 4);
            default: pick_count = $urandom;
        endcase
    endfunction

    task automatic random_requests(input int count);
        int roll;
        repeat (count) begin
            if ($urandom_range(0, 14) == 0) quiet = !quiet;
            roll = $urandom_range(0, 99);
            if (roll < 25)      send_request(REQ_PUSH_FRONT, pick_value());
            else if (roll < 50) send_request(REQ_PUSH_BACK, pick_value());
            else if (roll < 58) send_request(REQ_POP_FRONT, pick_value());
            else if (roll < 66) send_request(REQ_POP_BACK, pick_value());
            else if (roll < 74) send_request(REQ_DELETE, pick_value());
            else if (roll < 80) send_request(REQ_READ_ALL, pick_value());
            else if (roll < 87) send_request(REQ_READ_FIRST, pick_count());
            else if (roll < 94) send_request(REQ_READ_LAST, pick_count());
            else if (roll < 97) send_request(REQ_CLEAR, pick_value());
            else send_request(REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED)),
                              $urandom);
        end
    endtask

    // Stimulus and verdict
    initial begin
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_req_type <= REQ_PUSH_BACK;
        s_argument <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list: reads report empty status, pops and delete do nothing
        send_request(REQ_READ_ALL, 0);
        send_request(REQ_READ_FIRST, 3);
        send_request(REQ_POP_FRONT, 0);
        send_request(REQ_POP_BACK, 0);
        send_request(REQ_DELETE, 0);
        // extremes at both ends, adjacent duplicates
        send_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(REQ_PUSH_FRONT, 32'h8000_0000);
        send_request(REQ_PUSH_BACK, 5);
        send_request(REQ_PUSH_BACK, 5);
        send_request(REQ_PUSH_FRONT, -1);
        send_request(REQ_PUSH_BACK, 0);
        send_request(REQ_READ_ALL, 0);
        send_request(REQ_DELETE, 5);
        // zero, negative and clamped counts
        send_request(REQ_READ_FIRST, 0);
        send_request(REQ_READ_FIRST, 32'h8000_0000);
        send_request(REQ_READ_LAST, 32'hFFFF_FFFF);
        send_request(REQ_READ_FIRST, 100);
        send_request(REQ_READ_LAST, 2);
        send_request(REQ_POP_FRONT, 0);
        send_request(REQ_POP_BACK, 0);
        send_request(REQ_FIRST_UNUSED, 32'h1234_5678);
        send_request(REQ_LAST_UNUSED, -1);
        send_request(REQ_DELETE, 32'h7FFF_FFFF);
        send_request(REQ_READ_ALL, 0);
        send_request(REQ_CLEAR, 0);
        send_request(REQ_READ_LAST, 1);

        random_requests(4);

        // fill to capacity from both ends, overflow at both ends, full-length reads
        quiet = 1'b1;
        for (int i = 0; i < CAPACITY + 2; i++)
            send_request((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value());
        quiet = 1'b0;
        send_request(REQ_READ_ALL, 0);
        send_request(REQ_READ_LAST, CAPACITY + 6);
        send_request(REQ_DELETE, int'($urandom_range(0, 4)) - 2);
        send_request(REQ_READ_FIRST, CAPACITY);

        random_requests(4);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("bounded_deque_with_value_delete_core: match");
        else
            $display("bounded_deque_with_value_delete_core: mismatch");
        $finish;
    end

    // Result side: random stall before each transfer, none while quiet
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            repeat (stall) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Watchdog: ends the run after too long without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bounded_deque_with_value_delete_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
